// File: src/bse_pkg.sv
// Shared types and constants for the bitmap set engine.
// Used by every module of the block; depends on nothing.
package bse_pkg;

  localparam int CAPACITY   = 4096;
  localparam int WORD_BITS  = 8;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_COUNT = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int VALUE_W    = 12;
  localparam int COUNT_W    = 13;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_TEST   = 2'd2,
    ACT_FIND   = 2'd3
  } action_e;

  typedef struct packed {
    action_e              action;
    logic [VALUE_W-1:0]   value;
  } req_t;

  typedef struct packed {
    logic                 changed;
    logic                 was_member;
    logic                 found;
    logic [VALUE_W-1:0]   next_member;
    logic [COUNT_W-1:0]   count;
  } rsp_t;

  // A request after classification: word address, bit within the word and range flag.
  typedef struct packed {
    action_e              action;
    logic [ADDR_W-1:0]    word;
    logic [BIT_W-1:0]     bit_idx;
    logic                 in_range;
  } cmd_t;

  typedef struct packed {
    logic                 full;
    logic                 empty;
  } q_status_t;

endpackage

// File: src/bitmap_set_engine.sv
// Top level of the bitmap set engine: front, command queue and back.
// Depends on bse_pkg, bse_front, bse_queue and bse_back.
//
//   port group  direction  handshake               word
//   in          request    in_valid_i / in_stall_o  bse_pkg::req_t  in_data_i
//   out         result     out_valid_o / out_stall_i bse_pkg::rsp_t out_data_o
//
// Add, remove and test read one bitmap word; add and remove then write it back when they change it.
// Find next reads the start word and then the following words one by one, up to the last of the
// WORD_COUNT (512) words, since the bitmap memory is read one word a cycle.
// After reset a clearing pass writes zero to all WORD_COUNT (512) words, one a cycle;
// requests queue up to the queue depth meanwhile and then stall.
// A result waits in its output register while the next requests are queued.
module bitmap_set_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bse_pkg::req_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bse_pkg::rsp_t   out_data_o
);

  bse_pkg::q_status_t  q_stat;
  bse_pkg::cmd_t       push_cmd;
  bse_pkg::cmd_t       head_cmd;
  logic                push;
  logic                pop;

  bse_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  bse_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .q_stat_o    (q_stat)
  );

  bse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .head_i      (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef NO_ASSERTIONS
  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("command popped from an empty queue");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(out_data_o.count) <= 32'(bse_pkg::CAPACITY)))
    else $error("set count above capacity");

  a_found_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.found) |-> !out_data_o.changed)
    else $error("search result marked as changing the set");
`endif

endmodule

// File: src/bse_front.sv
// Front end of the bitmap set engine: accepts request words and classifies them.
// Depends on bse_pkg; feeds bse_queue.
module bse_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bse_pkg::req_t        in_data_i,
  input  bse_pkg::q_status_t   q_stat_i,
  output logic                 push_o,
  output bse_pkg::cmd_t        cmd_o
);

  logic [31:0] value_wide;

  assign value_wide = 32'(in_data_i.value);
  assign in_stall_o = q_stat_i.full;
  assign push_o     = in_valid_i && !q_stat_i.full;

  always_comb begin
    cmd_o.action   = in_data_i.action;
    cmd_o.word     = bse_pkg::ADDR_W'(value_wide / bse_pkg::WORD_BITS);
    cmd_o.bit_idx  = bse_pkg::BIT_W'(value_wide % bse_pkg::WORD_BITS);
    cmd_o.in_range = (value_wide < 32'(bse_pkg::CAPACITY));
  end

endmodule

// File: src/bse_queue.sv
// Short command queue between the front and the back of the bitmap set engine.
// Depends on bse_pkg.
module bse_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  bse_pkg::cmd_t        push_data_i,
  input  logic                 pop_i,
  output bse_pkg::cmd_t        head_o,
  output bse_pkg::q_status_t   q_stat_o
);

  bse_pkg::cmd_t                slot_q [bse_pkg::QUEUE_DEPTH];
  logic [bse_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [bse_pkg::QCNT_W-1:0]   fill_q;

  assign q_stat_o.full  = (fill_q == bse_pkg::QCNT_W'(bse_pkg::QUEUE_DEPTH));
  assign q_stat_o.empty = (fill_q == '0);
  assign head_o         = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == bse_pkg::QPTR_W'(bse_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == bse_pkg::QPTR_W'(bse_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: src/bse_back.sv
// Back end of the bitmap set engine: bitmap memory, clearing pass, execution and result register.
// Depends on bse_pkg; takes commands from bse_queue.
module bse_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bse_pkg::q_status_t   q_stat_i,
  input  bse_pkg::cmd_t        head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bse_pkg::rsp_t        out_data_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_e;

  localparam logic [bse_pkg::ADDR_W-1:0] LAST_WORD =
    bse_pkg::ADDR_W'(bse_pkg::WORD_COUNT - 1);

  state_e                          state_q;
  logic [bse_pkg::ADDR_W-1:0]      clr_q;
  logic [bse_pkg::ADDR_W-1:0]      scan_q;
  bse_pkg::cmd_t                   cmd_q;
  logic                            first_q;
  logic                            was_q;
  logic [bse_pkg::COUNT_W-1:0]     count_q;
  logic                            out_valid_q;
  bse_pkg::rsp_t                   out_q;
  bse_pkg::rsp_t                   out_d;

  logic [bse_pkg::WORD_BITS-1:0]   mem_q [bse_pkg::WORD_COUNT];
  logic [bse_pkg::WORD_BITS-1:0]   rdata_q;

  logic                            slot_free;
  logic                            bit_hit;
  logic                            was_now;
  logic [bse_pkg::WORD_BITS-1:0]   bit_mask;
  logic [bse_pkg::WORD_BITS-1:0]   masked;
  logic                            scan_more;
  logic                            rd_en;
  logic [bse_pkg::ADDR_W-1:0]      rd_addr;
  logic                            wr_en;
  logic [bse_pkg::ADDR_W-1:0]      wr_addr;
  logic [bse_pkg::WORD_BITS-1:0]   wr_data;

  // Position of the lowest set bit of a word.
  function automatic logic [bse_pkg::BIT_W-1:0] lowest_bit(
    input logic [bse_pkg::WORD_BITS-1:0] w
  );
    logic [bse_pkg::BIT_W-1:0] pos;
    pos = '0;
    for (int i = bse_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = bse_pkg::BIT_W'(i);
      end
    end
    return pos;
  endfunction

  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = (state_q == S_IDLE) && !q_stat_i.empty && slot_free;
  assign bit_hit   = rdata_q[cmd_q.bit_idx];
  assign was_now   = cmd_q.in_range && bit_hit;
  assign bit_mask  = bse_pkg::WORD_BITS'(1) << cmd_q.bit_idx;
  // Only the first word of a search ignores the bits below the start position.
  assign masked    = first_q ? (rdata_q & ({bse_pkg::WORD_BITS{1'b1}} << cmd_q.bit_idx))
                             : rdata_q;
  assign scan_more = (state_q == S_LOOK) && (cmd_q.action == bse_pkg::ACT_FIND) &&
                     cmd_q.in_range && (masked == '0) && (scan_q != LAST_WORD);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = head_i.word;
    if (pop_o) begin
      rd_en = 1'b1;
    end else if (scan_more) begin
      rd_en   = 1'b1;
      rd_addr = scan_q + 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmd_q.word;
    wr_data = rdata_q;
    case (state_q)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      S_LOOK: begin
        if (cmd_q.action == bse_pkg::ACT_ADD && cmd_q.in_range && !bit_hit) begin
          wr_en   = 1'b1;
          wr_data = rdata_q | bit_mask;
        end else if (cmd_q.action == bse_pkg::ACT_REMOVE && was_now) begin
          wr_en   = 1'b1;
          wr_data = rdata_q & ~bit_mask;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_d            = '0;
    out_d.was_member = first_q ? was_now : was_q;
    out_d.count      = count_q;
    case (cmd_q.action)
      bse_pkg::ACT_ADD: begin
        if (cmd_q.in_range && !bit_hit) begin
          out_d.changed = 1'b1;
          out_d.count   = count_q + 1'b1;
        end
      end
      bse_pkg::ACT_REMOVE: begin
        if (was_now) begin
          out_d.changed = 1'b1;
          out_d.count   = count_q - 1'b1;
        end
      end
      bse_pkg::ACT_FIND: begin
        if (cmd_q.in_range && masked != '0) begin
          out_d.found       = 1'b1;
          out_d.next_member = bse_pkg::VALUE_W'({scan_q, lowest_bit(masked)});
        end
      end
      default: begin
        out_d.changed = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      scan_q      <= '0;
      cmd_q       <= '0;
      first_q     <= 1'b0;
      was_q       <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LAST_WORD) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop_o) begin
            cmd_q   <= head_i;
            scan_q  <= head_i.word;
            first_q <= 1'b1;
            state_q <= S_LOOK;
          end
        end
        S_LOOK: begin
          first_q <= 1'b0;
          if (first_q) begin
            was_q <= was_now;
          end
          if (scan_more) begin
            scan_q <= scan_q + 1'b1;
          end else begin
            out_q       <= out_d;
            count_q     <= out_d.count;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/sv/bitmap_set_engine_tb.sv
// Self-checking testbench for bitmap_set_engine: a directed table and then random requests,
// each result checked field by field against a typed row or a behavioural model of the set.
// Depends on bse_pkg and the bitmap_set_engine RTL.
module bitmap_set_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1500;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 600;

  typedef struct {
    bse_pkg::req_t req;
    bit            typed;
    bse_pkg::rsp_t rsp;
  } table_row_t;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  bse_pkg::req_t in_data_i   = '0;
  logic          out_stall_i = 1'b0;
  logic          in_stall_o;
  logic          out_valid_o;
  bse_pkg::rsp_t out_data_o;

  // Bench copy of the set and its cardinality.
  bit                          member_ref [bse_pkg::CAPACITY];
  logic [bse_pkg::COUNT_W-1:0] member_total = '0;

  bse_pkg::rsp_t pending_results [$];
  table_row_t    stimulus_table [$];
  int            fail_count    = 0;
  int            send_idle_pct = 8;
  int            recv_idle_pct = 59;
  bit            hold_req      = 1'b0;

  bitmap_set_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Applies one request to the bench copy of the set and returns the result it should give.
  function automatic bse_pkg::rsp_t set_op_result(input bse_pkg::req_t r);
    bse_pkg::rsp_t o;
    int            p;
    o = '0;
    o.was_member = member_ref[r.value];
    case (r.action)
      bse_pkg::ACT_ADD: begin
        if (!member_ref[r.value]) begin
          member_ref[r.value] = 1'b1;
          member_total = member_total + 1'b1;
          o.changed = 1'b1;
        end
      end
      bse_pkg::ACT_REMOVE: begin
        if (member_ref[r.value]) begin
          member_ref[r.value] = 1'b0;
          member_total = member_total - 1'b1;
          o.changed = 1'b1;
        end
      end
      bse_pkg::ACT_TEST: begin
      end
      default: begin
        p = int'(r.value);
        while (p < bse_pkg::CAPACITY && !o.found) begin
          if (member_ref[p[bse_pkg::VALUE_W-1:0]]) begin
            o.found = 1'b1;
            o.next_member = p[bse_pkg::VALUE_W-1:0];
          end
          p++;
        end
      end
    endcase
    o.count = member_total;
    return o;
  endfunction

  task automatic add_row(input bse_pkg::action_e a, input int v, input bit typed,
                         input bit ch, input bit wm, input bit fd, input int nx,
                         input int cnt);
    table_row_t row;
    row.req.action      = a;
    row.req.value       = v[bse_pkg::VALUE_W-1:0];
    row.typed           = typed;
    row.rsp.changed     = ch;
    row.rsp.was_member  = wm;
    row.rsp.found       = fd;
    row.rsp.next_member = nx[bse_pkg::VALUE_W-1:0];
    row.rsp.count       = cnt[bse_pkg::COUNT_W-1:0];
    stimulus_table.push_back(row);
  endtask

  // Offers one request word and returns once it has been taken.
  task automatic offer_word(input bse_pkg::req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Most values come from the two ends of the range so that adds and removes collide often.
  function automatic logic [bse_pkg::VALUE_W-1:0] pick_value();
    logic [bse_pkg::VALUE_W-1:0] v;
    v = bse_pkg::VALUE_W'($urandom_range(bse_pkg::CAPACITY - 1));
    case ($urandom_range(9))
      0:       v = $urandom_range(1) ? '1 : '0;
      1, 2, 3,
      4, 5:    v[bse_pkg::VALUE_W-1:6] = $urandom_range(1) ? '1 : '0;
      default: ;
    endcase
    return v;
  endfunction

  function automatic bse_pkg::action_e pick_action();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) return bse_pkg::ACT_ADD;
    if (roll < 60) return bse_pkg::ACT_REMOVE;
    if (roll < 75) return bse_pkg::ACT_TEST;
    return bse_pkg::ACT_FIND;
  endfunction

  // Result side: checks each accepted result word, then chooses the stall for the next cycle.
  int hold_left  = 0;
  bit hold_taken = 1'b0;

  always @(posedge clk_i) begin
    bse_pkg::rsp_t exp_rsp;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, out_data_o);
        fail_count++;
      end else begin
        exp_rsp = pending_results.pop_front();
        if (out_data_o.changed !== exp_rsp.changed) begin
          $display("%0t: changed expected %0d actual %0d", $time,
                   exp_rsp.changed, out_data_o.changed);
          fail_count++;
        end
        if (out_data_o.was_member !== exp_rsp.was_member) begin
          $display("%0t: was_member expected %0d actual %0d", $time,
                   exp_rsp.was_member, out_data_o.was_member);
          fail_count++;
        end
        if (out_data_o.found !== exp_rsp.found) begin
          $display("%0t: found expected %0d actual %0d", $time,
                   exp_rsp.found, out_data_o.found);
          fail_count++;
        end
        if (out_data_o.next_member !== exp_rsp.next_member) begin
          $display("%0t: next_member expected %0d actual %0d", $time,
                   exp_rsp.next_member, out_data_o.next_member);
          fail_count++;
        end
        if (out_data_o.count !== exp_rsp.count) begin
          $display("%0t: count expected %0d actual %0d", $time,
                   exp_rsp.count, out_data_o.count);
          fail_count++;
        end
      end
    end
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    bse_pkg::rsp_t exp_rsp;
    bse_pkg::req_t r;
    // Rows from the empty set onwards; typed expectations are those that follow at a glance.
    add_row(bse_pkg::ACT_TEST,   0,    1, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_FIND,   0,    1, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_FIND,   4095, 1, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_ADD,    0,    1, 1, 0, 0, 0,    1);
    add_row(bse_pkg::ACT_ADD,    0,    1, 0, 1, 0, 0,    1);
    add_row(bse_pkg::ACT_ADD,    4095, 1, 1, 0, 0, 0,    2);
    add_row(bse_pkg::ACT_TEST,   4095, 1, 0, 1, 0, 0,    2);
    add_row(bse_pkg::ACT_FIND,   0,    1, 0, 1, 1, 0,    2);
    add_row(bse_pkg::ACT_FIND,   1,    1, 0, 0, 1, 4095, 2);
    add_row(bse_pkg::ACT_FIND,   4095, 1, 0, 1, 1, 4095, 2);
    add_row(bse_pkg::ACT_REMOVE, 4095, 1, 1, 1, 0, 0,    1);
    add_row(bse_pkg::ACT_REMOVE, 4095, 1, 0, 0, 0, 0,    1);
    add_row(bse_pkg::ACT_FIND,   1,    1, 0, 0, 0, 0,    1);
    add_row(bse_pkg::ACT_REMOVE, 0,    1, 1, 1, 0, 0,    0);
    add_row(bse_pkg::ACT_REMOVE, 0,    1, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_ADD,    2730, 0, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_ADD,    1365, 0, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_ADD,    7,    0, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_ADD,    8,    0, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_FIND,   1,    0, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_TEST,   1365, 0, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_FIND,   1366, 0, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_FIND,   2731, 0, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_REMOVE, 7,    0, 0, 0, 0, 0,    0);
    add_row(bse_pkg::ACT_FIND,   0,    0, 0, 0, 0, 0,    0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The block clears its bitmap after reset, so the first words wait in its queue.
    foreach (stimulus_table[i]) begin
      offer_word(stimulus_table[i].req);
      exp_rsp = set_op_result(stimulus_table[i].req);
      pending_results.push_back(stimulus_table[i].typed ? stimulus_table[i].rsp : exp_rsp);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 8;
      end
      if (n == 2 * RANDOM_WORDS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // A long hold-off on the result side while words keep coming fills the block up.
        hold_req = 1'b1;
      end
      r.action = pick_action();
      r.value  = pick_value();
      offer_word(r);
      pending_results.push_back(set_op_result(r));
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/bse_pkg.sv
src/bse_front.sv
src/bse_queue.sv
src/bse_back.sv
src/bitmap_set_engine.sv
tb/sv/bitmap_set_engine_tb.sv
